// ===== src/pkvm_pkg.sv =====
`timescale 1ns / 1ps
package pkvm_pkg;

   localparam int BUCKETS_DEFAULT = 32;
   localparam int CAPACITY_DEFAULT = 64;
   localparam int KEY_W = 64;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 7;

   typedef enum logic [0:0] {
      ACT_INSERT = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      action_type          action;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [VALUE_W-1:0]  found_value;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_HEAD,
      BK_READ,
      BK_CMP,
      BK_DONE
   } back_state_type;

   // Folds the key by XOR of shifted copies into a 16-bit value from which the bucket index is taken.
   function automatic logic [15:0] key_fold(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] x;
      begin
         x = k;
         x = x ^ (x >> 32);
         x = x ^ (x >> 16);
         x = x ^ (x >> 8);
         key_fold = x[15:0];
      end
   endfunction

endpackage

// ===== src/pointer_key_value_map_core.sv =====
`timescale 1ns / 1ps
// A request is hashed into the queue, then the back end reads the bucket head and walks the
// chain; each chain step costs one memory read and one compare in the back end. The back
// end finishes one request before it takes the next, and a stalled response holds the
// back end. A two-entry queue decouples hashing from the walk.
// Synchronous reset clears the entry count, and the back end then writes the empty mark
// into every bucket head before it takes the first request.
module pointer_key_value_map_core #(
   parameter int BUCKETS = pkvm_pkg::BUCKETS_DEFAULT,
   parameter int CAPACITY = pkvm_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pkvm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pkvm_pkg::rsp_type  rsp_data
);

   localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LINK_W = $clog2(CAPACITY + 1);

   logic                  q_valid, q_take;
   pkvm_pkg::req_type     q_req;
   logic [BUCKET_W-1:0]   q_bucket;

   pkvm_front #(.BUCKETS(BUCKETS), .BUCKET_W(BUCKET_W)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_req, .q_bucket
   );

   pkvm_back #(
      .BUCKETS(BUCKETS), .CAPACITY(CAPACITY), .BUCKET_W(BUCKET_W),
      .IDX_W(IDX_W), .LINK_W(LINK_W)
   ) u_back (
      .clock, .reset, .q_valid, .q_take, .q_req, .q_bucket,
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

// ===== src/pkvm_front.sv =====
`timescale 1ns / 1ps
module pkvm_front #(
   parameter int BUCKETS = pkvm_pkg::BUCKETS_DEFAULT,
   parameter int BUCKET_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pkvm_pkg::req_type     req_data,
   output logic                  q_valid,
   input  logic                  q_take,
   output pkvm_pkg::req_type     q_req,
   output logic [BUCKET_W-1:0]   q_bucket
);

   localparam int DEPTH = 2;

   pkvm_pkg::req_type       fifo_req_ff [DEPTH];
   logic [BUCKET_W-1:0]     fifo_bkt_ff [DEPTH];
   logic [1:0]              count_ff, count_in;
   logic                    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic                    push, pop;
   logic [15:0]             fold;
   logic [BUCKET_W-1:0]     fold_low;
   logic [BUCKET_W-1:0]     bucket;

   always_comb begin
      fold = pkvm_pkg::key_fold(req_data.key);
      fold_low = fold[BUCKET_W-1:0];
      if (32'(fold_low) >= 32'(BUCKETS)) begin
         bucket = BUCKET_W'(32'(fold_low) - 32'(BUCKETS));
      end else begin
         bucket = fold_low;
      end
   end

   assign req_stall = (count_ff == 2'(DEPTH));
   assign push = req_valid && !req_stall;
   assign pop = q_take && (count_ff != 2'd0);
   assign q_valid = (count_ff != 2'd0);
   assign q_req = fifo_req_ff[rd_ptr_ff];
   assign q_bucket = fifo_bkt_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_req_ff[wr_ptr_ff] <= req_data;
         fifo_bkt_ff[wr_ptr_ff] <= bucket;
      end
   end

endmodule

// ===== src/pkvm_back.sv =====
`timescale 1ns / 1ps
module pkvm_back #(
   parameter int BUCKETS = pkvm_pkg::BUCKETS_DEFAULT,
   parameter int CAPACITY = pkvm_pkg::CAPACITY_DEFAULT,
   parameter int BUCKET_W = 5,
   parameter int IDX_W = 6,
   parameter int LINK_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   input  pkvm_pkg::req_type     q_req,
   input  logic [BUCKET_W-1:0]   q_bucket,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pkvm_pkg::rsp_type     rsp_data
);

   localparam logic [LINK_W-1:0] EMPTY = LINK_W'(CAPACITY);
   localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(BUCKETS - 1);

   logic [LINK_W-1:0]           head_mem [BUCKETS];
   logic [pkvm_pkg::KEY_W-1:0]  key_mem [CAPACITY];
   logic [pkvm_pkg::VALUE_W-1:0] val_mem [CAPACITY];
   logic [LINK_W-1:0]           next_mem [CAPACITY];

   pkvm_pkg::back_state_type    state_ff, state_in;
   pkvm_pkg::req_type           req_ff;
   logic [BUCKET_W-1:0]         bkt_ff;
   logic [BUCKET_W-1:0]         clr_ff;
   logic [LINK_W-1:0]           head_rd_ff;
   logic [LINK_W-1:0]           cur_ff, cur_in, prev_ff, prev_in;
   logic [LINK_W-1:0]           steps_ff, steps_in;
   logic [LINK_W-1:0]           used_ff;
   logic [pkvm_pkg::KEY_W-1:0]  rd_key_ff;
   logic [pkvm_pkg::VALUE_W-1:0] rd_val_ff;
   logic [LINK_W-1:0]           rd_next_ff;
   logic                        out_valid_ff;
   pkvm_pkg::rsp_type           out_ff, out_in;
   logic                        cur_ok, hit, less, finish, do_ins, take_ok;
   logic [LINK_W-1:0]           head_val;

   assign head_val = head_rd_ff;
   assign cur_ok = (cur_ff < EMPTY) && (steps_ff < EMPTY);
   assign hit = cur_ok && (rd_key_ff == req_ff.key);
   assign less = cur_ok && (req_ff.key < rd_key_ff);
   assign finish = !cur_ok || hit || less;
   assign do_ins = (state_ff == pkvm_pkg::BK_CMP) && finish
      && (req_ff.action == pkvm_pkg::ACT_INSERT) && !hit && (used_ff < EMPTY);
   assign take_ok = q_valid && (!out_valid_ff || !rsp_stall);
   assign q_take = (state_ff == pkvm_pkg::BK_IDLE) && take_ok;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pkvm_pkg::BK_CLEAR: if (clr_ff == LAST_BUCKET) state_in = pkvm_pkg::BK_IDLE;
         pkvm_pkg::BK_IDLE: if (take_ok) state_in = pkvm_pkg::BK_HEAD;
         pkvm_pkg::BK_HEAD: state_in = pkvm_pkg::BK_READ;
         pkvm_pkg::BK_READ: state_in = pkvm_pkg::BK_CMP;
         pkvm_pkg::BK_CMP: state_in = finish ? pkvm_pkg::BK_DONE : pkvm_pkg::BK_READ;
         pkvm_pkg::BK_DONE: if (!out_valid_ff) state_in = pkvm_pkg::BK_IDLE;
         default: state_in = pkvm_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      cur_in = cur_ff;
      prev_in = prev_ff;
      steps_in = steps_ff;
      out_in = out_ff;
      unique case (state_ff)
         pkvm_pkg::BK_HEAD: begin
            cur_in = head_val;
            prev_in = EMPTY;
            steps_in = '0;
         end
         pkvm_pkg::BK_CMP: begin
            if (!finish) begin
               prev_in = cur_ff;
               cur_in = rd_next_ff;
               steps_in = steps_ff + 1'b1;
            end else begin
               out_in.found_value = '0;
               out_in.entry_count = pkvm_pkg::COUNT_W'(used_ff);
               if (req_ff.action == pkvm_pkg::ACT_LOOKUP) begin
                  out_in.status = hit ? pkvm_pkg::ST_OK : pkvm_pkg::ST_NOT_FOUND;
                  if (hit) out_in.found_value = rd_val_ff;
               end else if (hit) begin
                  out_in.status = pkvm_pkg::ST_DUPLICATE;
               end else if (used_ff >= EMPTY) begin
                  out_in.status = pkvm_pkg::ST_FULL;
               end else begin
                  out_in.status = pkvm_pkg::ST_OK;
                  out_in.entry_count = pkvm_pkg::COUNT_W'(used_ff + 1'b1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pkvm_pkg::BK_CLEAR;
         clr_ff <= '0;
         used_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == pkvm_pkg::BK_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (do_ins) used_ff <= used_ff + 1'b1;
         if (state_ff == pkvm_pkg::BK_DONE && !out_valid_ff) out_valid_ff <= 1'b1;
         else if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      steps_ff <= steps_in;
      if (state_ff == pkvm_pkg::BK_CMP && finish) out_ff <= out_in;
      if (q_take) begin
         req_ff <= q_req;
         bkt_ff <= q_bucket;
      end
      head_rd_ff <= head_mem[q_take ? q_bucket : bkt_ff];
      rd_key_ff <= key_mem[cur_in[IDX_W-1:0]];
      rd_val_ff <= val_mem[cur_in[IDX_W-1:0]];
      rd_next_ff <= next_mem[cur_in[IDX_W-1:0]];
      if (state_ff == pkvm_pkg::BK_CLEAR) head_mem[clr_ff] <= EMPTY;
      if (do_ins) begin
         key_mem[used_ff[IDX_W-1:0]] <= req_ff.key;
         val_mem[used_ff[IDX_W-1:0]] <= req_ff.value;
         next_mem[used_ff[IDX_W-1:0]] <= cur_ok ? cur_ff : EMPTY;
         if (prev_ff < EMPTY) next_mem[prev_ff[IDX_W-1:0]] <= used_ff;
         else head_mem[bkt_ff] <= used_ff;
      end
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   localparam int CAP = 64;
   localparam int RANDOM_ITEMS = 1800;
   localparam int CYCLE_LIMIT = 2000000;

   class map_scoreboard;
      logic [63:0] keys[$];
      logic [63:0] values[$];
      pkvm_pkg::rsp_type pending[$];
      int errors;

      function void note_request(pkvm_pkg::req_type r);
         pkvm_pkg::rsp_type e;
         int hit;
         hit = -1;
         foreach (keys[i]) begin
            if (keys[i] == r.key) hit = i;
         end
         e.found_value = '0;
         if (r.action == pkvm_pkg::ACT_LOOKUP) begin
            if (hit >= 0) begin
               e.status = pkvm_pkg::ST_OK;
               e.found_value = values[hit];
            end else begin
               e.status = pkvm_pkg::ST_NOT_FOUND;
            end
         end else if (hit >= 0) begin
            e.status = pkvm_pkg::ST_DUPLICATE;
         end else if (keys.size() >= CAP) begin
            e.status = pkvm_pkg::ST_FULL;
         end else begin
            keys.push_back(r.key);
            values.push_back(r.value);
            e.status = pkvm_pkg::ST_OK;
         end
         e.entry_count = 7'(keys.size());
         pending.push_back(e);
      endfunction

      function void check_response(pkvm_pkg::rsp_type a);
         pkvm_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.found_value !== e.found_value) begin
            $display("%0t: found_value expected %h actual %h", $time, e.found_value,
                     a.found_value);
            errors++;
         end
         if (a.entry_count !== e.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                     a.entry_count);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pkvm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pkvm_pkg::rsp_type rsp_data;

   map_scoreboard board = new();
   logic [63:0] key_pool[$];
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;

   pointer_key_value_map_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send(pkvm_pkg::action_type a, logic [63:0] k, logic [63:0] v);
      pkvm_pkg::req_type r;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      r.action = a;
      r.key = k;
      r.value = v;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_key();
      int s;
      s = $urandom_range(0, 9);
      if (s < 6 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (s < 8) return 64'($urandom_range(0, 200));
      return rand64();
   endfunction

   initial begin
      logic [63:0] k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(pkvm_pkg::ACT_LOOKUP, 64'h0, 64'h0);
      send(pkvm_pkg::ACT_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send(pkvm_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send(pkvm_pkg::ACT_INSERT, 64'h0, 64'h1234);
      send(pkvm_pkg::ACT_LOOKUP, 64'h0, 64'h55);
      send(pkvm_pkg::ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send(pkvm_pkg::ACT_INSERT, 64'h20, 64'hA5A5_A5A5_A5A5_A5A5);
      send(pkvm_pkg::ACT_INSERT, 64'h40, 64'h5A5A_5A5A_5A5A_5A5A);
      send(pkvm_pkg::ACT_INSERT, 64'h10, 64'h1);
      send(pkvm_pkg::ACT_LOOKUP, 64'h40, 64'h0);
      send(pkvm_pkg::ACT_LOOKUP, 64'h30, 64'h0);
      send(pkvm_pkg::ACT_LOOKUP, 64'h10, 64'h0);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            if (n == RANDOM_ITEMS / 6) drain();
            k = pick_key();
            if ($urandom_range(0, 1) == 0) begin
               if (board.keys.size() < CAP) key_pool.push_back(k);
               send(pkvm_pkg::ACT_INSERT, k, rand64());
            end else begin
               send(pkvm_pkg::ACT_LOOKUP, k, rand64());
            end
         end
      end
      drain();
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
src/pkvm_pkg.sv
src/pkvm_front.sv
src/pkvm_back.sv
src/pointer_key_value_map_core.sv
test/testbench.sv
